// ===== hw/rtl/mbd_pkg.sv =====
// Shared types, constants and helpers for the mipmap box downsampler.
package mbd_pkg;

    // Largest supported base size, as log2 of texels per side
    localparam int MAX_SIZE_LOG2 = 10;
    // One cell per produced mipmap level
    localparam int NUM_CELLS     = MAX_SIZE_LOG2;

    localparam int LOG2_W  = 4;                  // size register and level width
    localparam int POS_W   = MAX_SIZE_LOG2;      // column/row counter width
    localparam int IDX_W   = POS_W - 1;          // row buffer index, half a column
    localparam int CH_W    = 8;                  // one color channel
    localparam int PAIR_W  = CH_W + 1;           // sum of two texels
    localparam int SUM_W   = PAIR_W + 1;         // sum of four texels
    localparam int ROW_W   = 2 * PAIR_W;         // row buffer entry: lum pair, alpha pair

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LOG2_W-1:0] SIZE_LOG2_MAX = LOG2_W'(MAX_SIZE_LOG2);

    // Configuration register map, by word index
    typedef enum logic {
        REG_WIDTH_LOG2  = 1'b0,
        REG_HEIGHT_LOG2 = 1'b1
    } reg_idx_t;

    // Base-level texel on the input channel
    typedef struct packed {
        logic [CH_W-1:0] lum_in;
        logic [CH_W-1:0] alpha_in;
    } texel_t;

    // One produced mipmap texel
    typedef struct packed {
        logic [LOG2_W-1:0] level;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic [CH_W-1:0]   lum_out;
        logic [CH_W-1:0]   alpha_out;
        logic              last_of_run;
    } result_t;

    // Texel handed from one cell to the next
    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] lum;
        logic [CH_W-1:0] alpha;
    } link_t;

    // Status a cell shows its upstream neighbor
    typedef struct packed {
        logic active;   // this level exists for the current sizes
        logic pass;     // next texel here completes a 2x2 block
    } cell_stat_t;

    // Common configuration seen by every cell
    typedef struct packed {
        logic [LOG2_W-1:0] wl;
        logic [LOG2_W-1:0] hl;
        logic [LOG2_W-1:0] levels;
        logic              restart;
    } cfg_t;

    // Row buffer access from a cell
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ROW_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
        return (v > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : v;
    endfunction

endpackage

// ===== hw/rtl/mipmap_box_downsampler_unit.sv =====
// Top level of the streaming 2x2 box-filter mipmap generator.
//
// Base texels enter row-major, one per transfer, and every coarser mipmap level is built
// on the fly by a chain of ten identical level cells: cell k owns level k's column/row
// counters, the waiting even-column texel and a row buffer of 2^(9-k) pair sums (two
// for cell 9), and it hands each finished level k+1 texel to cell k+1 through a link
// register. Results come out finest level first, with last_of_run marking the final
// result caused by a base texel. The block takes one texel per cycle while the result
// queue has space; the one exception is a texel completing a level-1 block while a coarser
// texel is still walking down the chain; it waits for that walk. A two-entry result queue
// separates the chain from the result channel, so a stalled consumer stops the chain only
// once the queue is full. Writing either size register restarts the frame; write only while
// no transfer is in flight. Sizes above 10 act as 10; a 1x1 image produces no results.
module mipmap_box_downsampler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0]   paddr,
    input  logic [mbd_pkg::PDATA_W-1:0]   pwdata,
    output logic [mbd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          texel_valid,
    output logic                          texel_ready,
    input  mbd_pkg::texel_t               texel,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mbd_pkg::result_t              result
);
    import mbd_pkg::*;

    logic [LOG2_W-1:0]     width_log2_reg, height_log2_reg;
    logic [LOG2_W-1:0]     wl_c, hl_c, levels;
    logic                  cfg_wr;
    reg_idx_t              reg_sel;
    cfg_t                  cell_cfg;

    link_t                 cell_in  [NUM_CELLS];
    cell_stat_t            stat     [NUM_CELLS];
    cell_stat_t            nbr      [NUM_CELLS];
    ram_req_t              req      [NUM_CELLS];
    logic [ROW_W-1:0]      rd       [NUM_CELLS];
    result_t               res      [NUM_CELLS];
    logic [NUM_CELLS-1:0]  emit;

    logic [NUM_CELLS-1:1]  link_valid_reg, link_valid_next;
    logic [CH_W-1:0]       link_lum_reg   [1:NUM_CELLS-1];
    logic [CH_W-1:0]       link_alpha_reg [1:NUM_CELLS-1];

    logic                  emit_ok, busy, texel_fire, push;
    result_t               push_data;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg  <= '0;
            height_log2_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_WIDTH_LOG2:  width_log2_reg  <= pwdata[LOG2_W-1:0];
                REG_HEIGHT_LOG2: height_log2_reg <= pwdata[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WIDTH_LOG2:  prdata = PDATA_W'(width_log2_reg);
            REG_HEIGHT_LOG2: prdata = PDATA_W'(height_log2_reg);
            default:         prdata = '0;
        endcase
    end

    // Effective sizes and number of levels
    assign wl_c     = clamp_log2(width_log2_reg);
    assign hl_c     = clamp_log2(height_log2_reg);
    assign levels   = (wl_c > hl_c) ? wl_c : hl_c;
    assign cell_cfg = '{wl: wl_c, hl: hl_c, levels: levels, restart: cfg_wr};

    // Input handshake: needs queue space; a block-completing texel also waits for any carry
    assign busy        = |link_valid_reg;
    assign texel_ready = emit_ok && !(busy && stat[0].active && stat[0].pass);
    assign texel_fire  = texel_valid && texel_ready;

    // Chain of level cells with their row buffers
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        localparam int AW = ((MAX_SIZE_LOG2 - 1 - k) > 0) ? (MAX_SIZE_LOG2 - 1 - k) : 1;

        if (k == 0)
        begin : g_head
            assign cell_in[k] = '{valid: texel_fire, lum: texel.lum_in,
                                  alpha: texel.alpha_in};
        end
        else
        begin : g_link
            assign cell_in[k] = '{valid: link_valid_reg[k] && emit_ok,
                                  lum: link_lum_reg[k], alpha: link_alpha_reg[k]};

            always_ff @(posedge clk)
            begin
                if (emit_ok && emit[k-1])
                begin
                    link_lum_reg[k]   <= res[k-1].lum_out;
                    link_alpha_reg[k] <= res[k-1].alpha_out;
                end
            end
        end

        if (k == NUM_CELLS - 1)
        begin : g_tail
            assign nbr[k] = '0;
        end
        else
        begin : g_mid
            assign nbr[k] = stat[k+1];
        end

        mbd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .level_idx (LOG2_W'(k)),
            .cfg       (cell_cfg),
            .tin       (cell_in[k]),
            .nbr_stat  (nbr[k]),
            .rd_data   (rd[k]),
            .stat      (stat[k]),
            .ram_req   (req[k]),
            .res_valid (emit[k]),
            .res       (res[k])
        );

        mbd_ram #(
            .ADDR_W (AW),
            .DATA_W (ROW_W)
        ) u_ram (
            .clk   (clk),
            .we    (req[k].we),
            .waddr (req[k].waddr[AW-1:0]),
            .wdata (req[k].wdata),
            .raddr (req[k].raddr[AW-1:0]),
            .rdata (rd[k])
        );
    end

    // Carry valid bits: a level result moves on when the next level exists
    always_comb
    begin
        for (int k = 1; k < NUM_CELLS; k++)
        begin
            link_valid_next[k] = emit_ok ? (emit[k-1] && stat[k].active)
                                         : link_valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
        end
        else
        begin
            link_valid_reg <= link_valid_next;
        end
    end

    // Collect the single emitting cell of this cycle
    always_comb
    begin
        push_data = '0;
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            if (emit[k])
            begin
                push_data = res[k];
            end
        end
    end

    assign push = |emit;

    mbd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .space        (emit_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Checks
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(emit))
        else $error("more than one level cell emitted in a cycle");

    a_one_carry: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(link_valid_reg))
        else $error("more than one carry in flight along the chain");

    a_no_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (levels == '0) |-> !push && !busy)
        else $error("result produced for an image without smaller levels");

    a_carry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !emit_ok) |=> $stable(link_valid_reg))
        else $error("carry moved while the result queue was full");

endmodule

// ===== hw/rtl/mbd_ram.sv =====
// Single-port-write, single-port-read row buffer with registered, write-first read.
module mbd_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 18
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, new data forwarded on a same-address write
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mbd_cell.sv =====
// One mipmap level: position counters, held even-column texel and 2x2 averaging.
module mbd_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mbd_pkg::LOG2_W-1:0]        level_idx,
    input  mbd_pkg::cfg_t                     cfg,
    input  mbd_pkg::link_t                    tin,
    input  mbd_pkg::cell_stat_t               nbr_stat,
    input  logic [mbd_pkg::ROW_W-1:0]         rd_data,
    output mbd_pkg::cell_stat_t               stat,
    output mbd_pkg::ram_req_t                 ram_req,
    output logic                              res_valid,
    output mbd_pkg::result_t                  res
);
    import mbd_pkg::*;

    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic [2*CH_W-1:0]  held_reg;

    logic [LOG2_W-1:0]  wshift, hshift;
    logic [POS_W-1:0]   col_max, row_max;
    logic               w_one, h_one;
    logic               col_last, row_last;
    logic               pass_h, pass_v;
    logic               active, fire;
    logic [PAIR_W-1:0]  pl, pa;
    logic [SUM_W-1:0]   sl, sa;

    // Level geometry: side is 2^(log2 - level), or one texel once exhausted
    assign w_one   = (cfg.wl <= level_idx);
    assign h_one   = (cfg.hl <= level_idx);
    assign wshift  = cfg.wl - level_idx;
    assign hshift  = cfg.hl - level_idx;
    assign col_max = (POS_W'(1) << wshift) - POS_W'(1);
    assign row_max = (POS_W'(1) << hshift) - POS_W'(1);

    assign col_last = w_one || (col_reg == col_max);
    assign row_last = h_one || (row_reg == row_max);

    // Odd column (or single column) completes a horizontal pair
    assign pass_h = w_one || col_reg[0];
    assign pass_v = h_one || row_reg[0];

    assign active = (level_idx < cfg.levels);
    assign fire   = tin.valid && active;

    // Position of the next texel expected at this level
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (fire)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Even-column texel waits for its partner
    always_ff @(posedge clk)
    begin
        if (fire && !pass_h)
        begin
            held_reg <= {tin.alpha, tin.lum};
        end
    end

    // Horizontal pair sums
    assign pl = w_one ? {tin.lum, 1'b0}
                      : PAIR_W'(held_reg[CH_W-1:0]) + PAIR_W'(tin.lum);
    assign pa = w_one ? {tin.alpha, 1'b0}
                      : PAIR_W'(held_reg[2*CH_W-1:CH_W]) + PAIR_W'(tin.alpha);

    // Vertical sums with the pair stored on the even row
    assign sl = h_one ? {pl, 1'b0}
                      : SUM_W'(rd_data[PAIR_W-1:0]) + SUM_W'(pl);
    assign sa = h_one ? {pa, 1'b0}
                      : SUM_W'(rd_data[ROW_W-1:PAIR_W]) + SUM_W'(pa);

    // Row buffer: store on even rows, prefetch for the next position
    assign ram_req.we    = fire && pass_h && !pass_v;
    assign ram_req.waddr = col_reg[POS_W-1:1];
    assign ram_req.wdata = {pa, pl};
    assign ram_req.raddr = col_next[POS_W-1:1];

    // Result of this level
    assign res_valid       = fire && pass_h && pass_v;
    assign res.level       = level_idx + LOG2_W'(1);
    assign res.col         = col_reg[POS_W-1:1];
    assign res.row         = row_reg[POS_W-1:1];
    assign res.lum_out     = sl[SUM_W-1:2];
    assign res.alpha_out   = sa[SUM_W-1:2];
    assign res.last_of_run = !nbr_stat.active || !nbr_stat.pass;

    assign stat.active = active;
    assign stat.pass   = pass_h && pass_v;

endmodule

// ===== hw/rtl/mbd_out_buf.sv =====
// Two-entry result queue that decouples the cell chain from the result channel.
module mbd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbd_pkg::result_t  push_data,
    output logic              space,
    output logic              result_valid,
    input  logic              result_ready,
    output mbd_pkg::result_t  result
);
    import mbd_pkg::*;

    localparam logic [1:0] FULL_COUNT = 2'd2;

    result_t     slot_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic        pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != 2'd0);
    assign result       = slot_reg[rd_ptr_reg];
    assign space        = (count_reg < FULL_COUNT);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== bench/mipmap_box_downsampler_unit_tb.sv =====
// Self-checking testbench for the streaming 2x2 box-filter mipmap generator.
`timescale 1ns / 1ps

module mipmap_box_downsampler_unit_tb;

    import mbd_pkg::*;

    localparam int SETTLE_CYCLES = 32;    // chain depth plus result queue, with margin
    localparam int STALL_CYCLES  = 300;   // long consumer hold-off
    localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
    localparam int ROW_SLOTS     = 1 << (MAX_SIZE_LOG2 - 1);

    // Directed stimulus rows
    typedef enum logic [1:0] {
        ROW_SET_WIDTH,
        ROW_SET_HEIGHT,
        ROW_FEED,
        ROW_FEED_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [LOG2_W-1:0] size_val;
        texel_t            px;
        logic              has_mip;
        result_t           mip;
    } dir_row_t;

    localparam result_t NO_MIP = '0;
    localparam int DIRECTED_ROWS = 27;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                texel_valid;
    logic                texel_ready;
    texel_t              texel;
    logic                result_valid;
    logic                result_ready;
    result_t             result;

    // Predictor state: registers, per-level counters and stores
    logic [LOG2_W-1:0]   cfg_wl;
    logic [LOG2_W-1:0]   cfg_hl;
    logic [ROW_W-1:0]    pair_rows [MAX_SIZE_LOG2][ROW_SLOTS];
    logic [2*CH_W-1:0]   held_px [MAX_SIZE_LOG2];
    int unsigned         lvl_col [MAX_SIZE_LOG2+1];
    int unsigned         lvl_row [MAX_SIZE_LOG2+1];

    result_t             pending_mips [$];
    int                  mismatches   = 0;
    int                  results_seen = 0;
    int                  texels_fed   = 0;
    int                  quiet_cycles = 0;
    bit                  steady       = 1'b0;
    bit                  stall_req    = 1'b0;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        // sizes at reset: 1x1, nothing comes out
        '{ROW_FEED_KNOWN, 4'd0, '{8'h12, 8'h34}, 1'b0, NO_MIP},
        // 2x1 image: every pair gives one level-1 texel
        '{ROW_SET_WIDTH, 4'd1, '0, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'hFF, 8'hFF}, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'hFF, 8'hFF}, 1'b1,
          '{4'd1, 9'd0, 9'd0, 8'hFF, 8'hFF, 1'b1}},
        '{ROW_FEED_KNOWN, 4'd0, '{8'h00, 8'h00}, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'h00, 8'h00}, 1'b1,
          '{4'd1, 9'd0, 9'd0, 8'h00, 8'h00, 1'b1}},
        '{ROW_FEED_KNOWN, 4'd0, '{8'hFF, 8'h00}, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'h00, 8'hFF}, 1'b1,
          '{4'd1, 9'd0, 9'd0, 8'h7F, 8'h7F, 1'b1}},
        '{ROW_FEED_KNOWN, 4'd0, '{8'h01, 8'h03}, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'h02, 8'h00}, 1'b1,
          '{4'd1, 9'd0, 9'd0, 8'h01, 8'h01, 1'b1}},
        // back to 1x1
        '{ROW_SET_WIDTH, 4'd0, '0, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'hAA, 8'h55}, 1'b0, NO_MIP},
        '{ROW_FEED_KNOWN, 4'd0, '{8'h55, 8'hAA}, 1'b0, NO_MIP},
        // oversized width saturates: 1024x1 row, partial
        '{ROW_SET_WIDTH, 4'd15, '0, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h80, 8'h10}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h7F, 8'hEF}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h01, 8'hFE}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'hC3, 8'h3C}, 1'b0, NO_MIP},
        // 1x4 column: single-texel width counts twice
        '{ROW_SET_WIDTH, 4'd0, '0, 1'b0, NO_MIP},
        '{ROW_SET_HEIGHT, 4'd2, '0, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h20, 8'h40}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h60, 8'h80}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'hA0, 8'hC0}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'hE0, 8'hFF}, 1'b0, NO_MIP},
        // tallest column, partial
        '{ROW_SET_HEIGHT, 4'd10, '0, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h11, 8'hEE}, 1'b0, NO_MIP},
        '{ROW_FEED, 4'd0, '{8'h99, 8'h66}, 1'b0, NO_MIP}
    };

    mipmap_box_downsampler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .texel_valid  (texel_valid),
        .texel_ready  (texel_ready),
        .texel        (texel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Compute the mip texels that one base texel completes, finest level first
    task automatic predict_mips(input texel_t px, output result_t mips[$]);
        int unsigned wl, hl, levels, tl, ta, wk, hk, x, y, idx, pl, pa, sl, sa, k;
        result_t r;
        mips.delete();
        wl = (cfg_wl > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : cfg_wl;
        hl = (cfg_hl > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : cfg_hl;
        levels = (wl > hl) ? wl : hl;
        tl = px.lum_in;
        ta = px.alpha_in;
        for (k = 0; k < levels; k++)
        begin
            wk = (wl >= k) ? (1 << (wl - k)) : 1;
            hk = (hl >= k) ? (1 << (hl - k)) : 1;
            x = lvl_col[k];
            y = lvl_row[k];
            // advance this level's raster position, wrapping at frame end
            if (x + 1 >= wk)
            begin
                lvl_col[k] = 0;
                lvl_row[k] = (y + 1 >= hk) ? 0 : y + 1;
            end
            else
            begin
                lvl_col[k] = x + 1;
            end
            // horizontal pair: a one-wide level pairs the texel with itself
            if (wk == 1)
            begin
                pl = tl * 2;
                pa = ta * 2;
            end
            else if (x[0] == 1'b0)
            begin
                held_px[k] = {ta[CH_W-1:0], tl[CH_W-1:0]};
                break;
            end
            else
            begin
                pl = held_px[k][CH_W-1:0] + tl;
                pa = held_px[k][2*CH_W-1:CH_W] + ta;
            end
            // vertical pair: even rows park their pair sum
            idx = (x >> 1) & ((1 << (MAX_SIZE_LOG2 - 1 - k)) - 1);
            if (hk == 1)
            begin
                sl = pl * 2;
                sa = pa * 2;
            end
            else if (y[0] == 1'b0)
            begin
                pair_rows[k][idx] = {pa[PAIR_W-1:0], pl[PAIR_W-1:0]};
                break;
            end
            else
            begin
                sl = pair_rows[k][idx][PAIR_W-1:0] + pl;
                sa = pair_rows[k][idx][ROW_W-1:PAIR_W] + pa;
            end
            tl = (sl >> 2) & 8'hFF;
            ta = (sa >> 2) & 8'hFF;
            r.level       = LOG2_W'(k + 1);
            r.col         = IDX_W'(x >> 1);
            r.row         = IDX_W'(y >> 1);
            r.lum_out     = CH_W'(tl);
            r.alpha_out   = CH_W'(ta);
            r.last_of_run = 1'b0;
            mips.push_back(r);
        end
        if (mips.size() > 0)
            mips[mips.size()-1].last_of_run = 1'b1;
    endtask

    // APB write of one size register; restarts the frame in the predictor as well
    task automatic write_size(input reg_idx_t ri, input logic [LOG2_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ri, 2'b00};
        pwdata  <= PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (ri == REG_WIDTH_LOG2)
            cfg_wl = v;
        else
            cfg_hl = v;
        for (int i = 0; i <= MAX_SIZE_LOG2; i++)
        begin
            lvl_col[i] = 0;
            lvl_row[i] = 0;
        end
        @(posedge clk);
    endtask

    // Stop offering texels and wait for every expected mip texel, then linger
    task automatic drain_results(input int extra);
        texel_valid <= 1'b0;
        do @(posedge clk); while (pending_mips.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // One texel transfer; expectations come from the predictor or a fixed list
    task automatic feed_texel(input texel_t px, input bit use_fixed, input result_t fixed_mips[$]);
        result_t mips[$];
        if (!steady && $urandom_range(99) < 13)
        begin
            texel_valid <= 1'b0;
            @(posedge clk);
        end
        texel_valid <= 1'b1;
        texel       <= px;
        do @(posedge clk); while (!texel_ready);
        texels_fed++;
        predict_mips(px, mips);
        if (use_fixed)
            mips = fixed_mips;
        foreach (mips[i])
            pending_mips.push_back(mips[i]);
    endtask

    function automatic void check_field(input string name, input logic [IDX_W-1:0] want,
                                        input logic [IDX_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result consumer: random back-pressure plus one long hold-off on request
    initial
    begin : result_sink
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                result_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_mips.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_mips.pop_front();
                check_field("level", IDX_W'(want.level), IDX_W'(result.level));
                check_field("col", want.col, result.col);
                check_field("row", want.row, result.row);
                check_field("lum_out", IDX_W'(want.lum_out), IDX_W'(result.lum_out));
                check_field("alpha_out", IDX_W'(want.alpha_out), IDX_W'(result.alpha_out));
                check_field("last_of_run", IDX_W'(want.last_of_run),
                            IDX_W'(result.last_of_run));
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin : watchdog
        if ((texel_valid && texel_ready) || (result_valid && result_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        result_t     fixed_mips [$];
        texel_t      px;
        int unsigned phase, n_items, big, other, wsel, hsel;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        texel_valid <= 1'b0;
        texel       <= '0;
        cfg_wl = '0;
        cfg_hl = '0;
        for (int i = 0; i <= MAX_SIZE_LOG2; i++)
        begin
            lvl_col[i] = 0;
            lvl_row[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_SET_WIDTH:
                begin
                    drain_results(SETTLE_CYCLES);
                    write_size(REG_WIDTH_LOG2, directed_rows[i].size_val);
                end
                ROW_SET_HEIGHT:
                begin
                    drain_results(SETTLE_CYCLES);
                    write_size(REG_HEIGHT_LOG2, directed_rows[i].size_val);
                end
                ROW_FEED:
                begin
                    feed_texel(directed_rows[i].px, 1'b0, fixed_mips);
                end
                default:
                begin
                    fixed_mips.delete();
                    if (directed_rows[i].has_mip)
                        fixed_mips.push_back(directed_rows[i].mip);
                    feed_texel(directed_rows[i].px, 1'b1, fixed_mips);
                end
            endcase
        end
        fixed_mips.delete();

        // Random frames: mostly small whole frames, some oversized partial ones
        phase = 0;
        while (phase < 8 || texels_fed < 260 || results_seen < 48)
        begin
            steady = (phase >= 4 && phase <= 7);
            if (phase == 2)
            begin
                wsel    = 3;
                hsel    = 3;
                n_items = 64;
            end
            else
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        big   = $urandom_range(15, 10);
                        other = $urandom_range(1);
                        if ($urandom_range(1))
                        begin
                            wsel = big;
                            hsel = other;
                        end
                        else
                        begin
                            wsel = other;
                            hsel = big;
                        end
                        n_items = $urandom_range(40, 24);
                    end
                    1:
                    begin
                        wsel    = $urandom_range(15, 10);
                        hsel    = $urandom_range(15, 10);
                        n_items = 16;
                    end
                    default:
                    begin
                        wsel    = $urandom_range(3);
                        hsel    = $urandom_range(3);
                        n_items = $urandom_range(2, 1) << (wsel + hsel);
                    end
                endcase
            end
            drain_results(SETTLE_CYCLES);
            if ($urandom_range(1))
            begin
                write_size(REG_WIDTH_LOG2, LOG2_W'(wsel));
                write_size(REG_HEIGHT_LOG2, LOG2_W'(hsel));
            end
            else
            begin
                write_size(REG_HEIGHT_LOG2, LOG2_W'(hsel));
                write_size(REG_WIDTH_LOG2, LOG2_W'(wsel));
            end
            // consumer holds off while an 8x8 frame keeps coming
            if (phase == 2)
                stall_req = 1'b1;
            for (int i = 0; i < n_items; i++)
            begin
                // sender pauses mid-frame until everything is out
                if (phase == 5 && i == n_items / 2)
                    drain_results(1);
                case ($urandom_range(7))
                    0: px = '0;
                    1: px = '1;
                    default:
                    begin
                        px.lum_in   = CH_W'($urandom);
                        px.alpha_in = CH_W'($urandom);
                    end
                endcase
                feed_texel(px, 1'b0, fixed_mips);
            end
            phase++;
        end

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0 && pending_mips.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
